@@ design/assert_macros.svh @@
// assertion helpers used by sorted_id_set_insert
// clocked on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge
`define SIS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sis assertion failed");

// condition must never be true at a clock edge
`define SIS_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("sis forbidden condition seen");

`else

`define SIS_ASSERT(label, prop)
`define SIS_ASSERT_NEVER(label, cond)

`endif

`endif

@@ design/sis_pkg.sv @@
package sis_pkg;

  // list geometry
  localparam int LIST_DEPTH = 256;
  localparam int ID_BITS    = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  // count never exceeds LIST_DEPTH-1, so it fits the index width
  localparam int CNT_W      = IDX_W;

  // word field widths
  localparam int NEW_ID_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = 8;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_OVERFLOW  = 2'd2,
    STAT_RANGE_UPD = 2'd3
  } status_e;

endpackage

@@ design/sis_if.sv @@
// input channel: one id per word
interface sis_in_if import sis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NEW_ID_W-1:0] new_id;

  modport source (output valid, output new_id, input ready);
  modport sink   (input valid, input new_id, output ready);
endinterface

// result channel: one word per accepted id
interface sis_out_if import sis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  entry_count;
  logic                range_mode;

  modport source (output valid, output status, output slot, output entry_count,
                  output range_mode, input ready);
  modport sink   (input valid, input status, input slot, input entry_count,
                  input range_mode, output ready);
endinterface

@@ design/sis_ram.sv @@
module sis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ design/sorted_id_set_insert.sv @@
// Sorted ID set. Each input word carries one ID; the block inserts it into a
// list kept highest first in a single simple dual-port RAM (one write and one
// registered read per cycle) and returns exactly one result word per ID:
// status (inserted, duplicate, overflowed into range, range widened), the
// one-based slot, the entry count and the range flag. A binary search issues
// each probe address, then compares on the registered read data; a final read
// checks for a duplicate, and an insert then moves the lower entries down one
// place per cycle. A duplicate ends after that check, and an ID seen once the
// set has collapsed into a low-high range needs no search. When an insert
// would fill the list to LIST_DEPTH entries the list collapses into a range
// bounded by its first and last entries and the new ID, and from then on IDs
// only widen that range. One ID is worked on at a time; a finished result sits
// in an output register, so the next ID is taken while the previous result
// still waits. Reset empties the set; no RAM clearing is needed since only
// written entries are ever read.
`include "assert_macros.svh"

module sorted_id_set_insert import sis_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sis_in_if.sink    in_i,
  sis_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,      // waiting for an id
    S_SEARCH,    // issue a probe read or finish the search
    S_SWAIT,     // compare probe data, narrow the window
    S_CHECK,     // compare entry at the found place for a duplicate
    S_OVF_FIRST, // first (largest) entry arrives
    S_OVF_LAST,  // last (smallest) entry arrives, collapse to range
    S_SHIFT,     // move entries down, then drop the id in
    S_EMIT       // hand the result to the output register
  } state_e;

  state_e              state_q, state_d;
  logic [ID_BITS-1:0]  id_q, id_d;
  logic [CNT_W-1:0]    lo_q, lo_d;         // search window, ends at the place
  logic [CNT_W-1:0]    hi_q, hi_d;
  logic [CNT_W-1:0]    k_q, k_d;           // next shift target
  logic                pend_q, pend_d;     // a moved entry waits to be written
  logic [IDX_W-1:0]    waddr_q, waddr_d;
  logic [ID_BITS-1:0]  big_q, big_d;       // upper bound while collapsing
  logic [CNT_W-1:0]    held_q, held_d;
  logic                is_range_q, is_range_d;
  logic [ID_BITS-1:0]  range_low_q, range_low_d;
  logic [ID_BITS-1:0]  range_high_q, range_high_d;
  status_e             res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_range_q, out_range_d;

  // ram controls
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  logic               in_fire;
  logic [ID_BITS-1:0] in_id;
  logic [CNT_W-1:0]   mid;
  logic               list_full;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_id      = ID_BITS'(in_i.new_id);
  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  // one more entry would make the list LIST_DEPTH long
  assign list_full  = (held_q == CNT_W'(LIST_DEPTH - 1));

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.slot        = out_slot_q;
  assign out_o.entry_count = out_count_q;
  assign out_o.range_mode  = out_range_q;

  sis_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    id_d         = id_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    k_d          = k_q;
    pend_d       = pend_q;
    waddr_d      = waddr_q;
    big_d        = big_q;
    held_d       = held_q;
    is_range_d   = is_range_q;
    range_low_d  = range_low_q;
    range_high_d = range_high_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    // output register drains independently of the work in progress
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    out_range_d  = out_range_q;

    ram_we    = 1'b0;
    ram_waddr = waddr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = mid;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          id_d       = in_id;
          res_slot_d = '0;
          if (is_range_q) begin
            // range mode: inside is a duplicate, outside widens one bound
            if (in_id >= range_low_q && in_id <= range_high_q) begin
              res_status_d = STAT_DUPLICATE;
            end else begin
              if (in_id < range_low_q) begin
                range_low_d = in_id;
              end else begin
                range_high_d = in_id;
              end
              res_status_d = STAT_RANGE_UPD;
            end
            state_d = S_EMIT;
          end else begin
            lo_d    = '0;
            hi_d    = held_q;
            state_d = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = mid;
          state_d   = S_SWAIT;
        end else if (lo_q < held_q) begin
          // look at the entry at the place for a duplicate
          ram_re    = 1'b1;
          ram_raddr = lo_q;
          state_d   = S_CHECK;
        end else if (list_full) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = S_OVF_FIRST;
        end else begin
          k_d     = held_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end

      S_SWAIT: begin
        if (ram_rdata > id_q) begin
          lo_d = mid + CNT_W'(1);
        end else begin
          hi_d = mid;
        end
        state_d = S_SEARCH;
      end

      S_CHECK: begin
        if (ram_rdata == id_q) begin
          res_status_d = STAT_DUPLICATE;
          state_d      = S_EMIT;
        end else if (list_full) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = S_OVF_FIRST;
        end else begin
          k_d     = held_q;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end
      end

      S_OVF_FIRST: begin
        big_d     = (ram_rdata > id_q) ? ram_rdata : id_q;
        ram_re    = 1'b1;
        ram_raddr = held_q - CNT_W'(1);
        state_d   = S_OVF_LAST;
      end

      S_OVF_LAST: begin
        range_low_d  = (ram_rdata < id_q) ? ram_rdata : id_q;
        range_high_d = big_q;
        is_range_d   = 1'b1;
        held_d       = '0;
        res_status_d = STAT_OVERFLOW;
        state_d      = S_EMIT;
      end

      S_SHIFT: begin
        // read k-1 while the entry read last cycle lands at k+1
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_q;
          ram_wdata = ram_rdata;
        end
        if (k_q > lo_q) begin
          ram_re    = 1'b1;
          ram_raddr = k_q - CNT_W'(1);
          pend_d    = 1'b1;
          waddr_d   = k_q;
          k_d       = k_q - CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            // gap is open: store the id
            ram_we       = 1'b1;
            ram_waddr    = lo_q;
            ram_wdata    = id_q;
            held_d       = held_q + CNT_W'(1);
            res_status_d = STAT_INSERTED;
            res_slot_d   = SLOT_W'(lo_q + CNT_W'(1));
            state_d      = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_count_d  = COUNT_W'(held_q);
          out_range_d  = is_range_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      id_q         <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      k_q          <= '0;
      pend_q       <= 1'b0;
      waddr_q      <= '0;
      big_q        <= '0;
      held_q       <= '0;
      is_range_q   <= 1'b0;
      range_low_q  <= '0;
      range_high_q <= '0;
      res_status_q <= STAT_INSERTED;
      res_slot_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_INSERTED;
      out_slot_q   <= '0;
      out_count_q  <= '0;
      out_range_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      id_q         <= id_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      k_q          <= k_d;
      pend_q       <= pend_d;
      waddr_q      <= waddr_d;
      big_q        <= big_d;
      held_q       <= held_d;
      is_range_q   <= is_range_d;
      range_low_q  <= range_low_d;
      range_high_q <= range_high_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_count_q  <= out_count_d;
      out_range_q  <= out_range_d;
    end
  end

  // range mode leaves the list empty
  `SIS_ASSERT_NEVER(a_range_list_empty, is_range_q && (held_q != '0))
  // range bounds stay ordered
  `SIS_ASSERT(a_range_ordered, is_range_q |-> (range_low_q <= range_high_q))
  // the store is only written while an id is being inserted
  `SIS_ASSERT(a_write_in_shift, ram_we |-> (state_q == S_SHIFT))
  // a shift never reads the entry it writes in the same cycle
  `SIS_ASSERT_NEVER(a_no_rw_clash, ram_we && ram_re && (ram_waddr == ram_raddr))
  // a new result only appears when leaving the emit state
  `SIS_ASSERT(a_result_from_emit, $rose(out_valid_q) |-> $past(state_q == S_EMIT))

endmodule
